// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the same cycle once the antecedent is seen.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Property that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/jlvs_pkg.sv -----
// Shared types and constants of the velocity shaper.
package jlvs_pkg;

    localparam int Q_W       = 24;
    localparam int DT_W      = 17;
    localparam int DIV_W     = 56;
    localparam int DIV_STEPS = 56;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W     = 6;

    localparam logic [31:0] US_PER_S = 32'd1000000;

    // floor(2^51 / 10^6): applied to the dividend shifted right by 9, then shifted by 42.
    localparam logic [31:0] RECIP_1M = 32'd2251799813;
    localparam int          RECIP_SH = 42;

    localparam logic [17:0] SPEED_RST = 18'd51200;
    localparam logic [19:0] ACCEL_RST = 20'd64000;
    localparam logic [23:0] JERK_RST  = 24'd460800;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_ACCEL = 2'd1;
    localparam logic [1:0] REG_JERK  = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2,
        OP_DIVM = 2'd3
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_cmd;

endpackage

// ----- src/jlvs_if.sv -----
// Request channel interfaces for shaper inputs and results.
interface jlvs_in_if import jlvs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   active;
    logic signed [Q_W-1:0]  setpoint_x;
    logic signed [Q_W-1:0]  setpoint_y;
    logic [DT_W-1:0]        step_us;

    modport source (output valid, active, setpoint_x, setpoint_y, step_us, input ready);
    modport sink (input valid, active, setpoint_x, setpoint_y, step_us, output ready);
endinterface

interface jlvs_out_if import jlvs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [Q_W-1:0]  target_x;
    logic signed [Q_W-1:0]  target_y;
    logic signed [Q_W-1:0]  accel_out_x;
    logic signed [Q_W-1:0]  accel_out_y;
    logic                   snapped;

    modport source (output valid, target_x, target_y, accel_out_x, accel_out_y, snapped,
                    input ready);
    modport sink (input valid, target_x, target_y, accel_out_x, accel_out_y, snapped,
                  output ready);
endinterface

// ----- src/jlvs_alu.sv -----
// Shared arithmetic unit: multiply, bit-serial divide, square root and divide by one million.
module jlvs_alu import jlvs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_cmd    i_cmd,
    input  logic [63:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_res,
    output logic        o_done
);

    logic             r_busy;
    logic             r_done;
    t_op              r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_x;
    logic [32:0]      r_rem;
    logic [31:0]      r_root;
    logic [31:0]      r_div;
    logic [63:0]      r_res;

    logic        divm_busy;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] q_rem;
    logic        q_fix;
    logic [32:0] d_t;
    logic        d_ge;
    logic [32:0] d_rem;
    logic [34:0] s_t;
    logic [34:0] s_trial;
    logic        s_ge;
    logic [34:0] s_rem;

    // The divide by one million borrows the multiplier: first the reciprocal estimate,
    // then the estimate times one million, which is at most one below the quotient.
    assign divm_busy = r_busy && (r_op == OP_DIVM);
    assign mul_a = divm_busy ? (r_cnt[0] ? r_x[40:9] : r_root) : i_a[31:0];
    assign mul_b = divm_busy ? (r_cnt[0] ? RECIP_1M : US_PER_S) : i_b;
    assign mul_p = mul_a * mul_b;
    assign q_rem = r_x - mul_p;
    assign q_fix = q_rem >= 64'(US_PER_S);

    // Restoring divide: one quotient bit per cycle, shifted into the low end of r_x.
    assign d_t   = {r_rem[31:0], r_x[DIV_W-1]};
    assign d_ge  = d_t >= {1'b0, r_div};
    assign d_rem = d_ge ? d_t - {1'b0, r_div} : d_t;

    // Digit-by-digit square root, two radicand bits per cycle.
    assign s_t     = {r_rem, r_x[63:62]};
    assign s_trial = {1'b0, r_root, 2'b01};
    assign s_ge    = s_t >= s_trial;
    assign s_rem   = s_ge ? s_t - s_trial : s_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                unique case (i_cmd.op)
                    OP_MUL: begin
                        r_res  <= mul_p;
                        r_done <= 1'b1;
                    end
                    OP_DIV: begin
                        r_x    <= i_a;
                        r_div  <= i_b;
                        r_rem  <= '0;
                        r_cnt  <= CNT_W'(DIV_STEPS - 1);
                        r_busy <= 1'b1;
                        r_op   <= OP_DIV;
                    end
                    OP_SQRT: begin
                        r_x    <= i_a;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= CNT_W'(SQRT_STEPS - 1);
                        r_busy <= 1'b1;
                        r_op   <= OP_SQRT;
                    end
                    OP_DIVM: begin
                        r_x    <= i_a;
                        r_cnt  <= CNT_W'(1);
                        r_busy <= 1'b1;
                        r_op   <= OP_DIVM;
                    end
                    default: ;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                unique case (r_op)
                    OP_DIV: begin
                        r_rem <= d_rem;
                        r_x   <= {r_x[62:0], d_ge};
                    end
                    OP_SQRT: begin
                        r_rem  <= s_rem[32:0];
                        r_root <= {r_root[30:0], s_ge};
                        r_x    <= {r_x[61:0], 2'b00};
                    end
                    OP_DIVM: begin
                        if (r_cnt[0]) begin
                            r_root <= 32'(mul_p[63:RECIP_SH]);
                        end
                    end
                    default: ;
                endcase
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    unique case (r_op)
                        OP_DIV:  r_res <= {8'd0, r_x[DIV_W-2:0], d_ge};
                        OP_SQRT: r_res <= {32'd0, r_root[30:0], s_ge};
                        OP_DIVM: r_res <= 64'(r_root) + 64'(q_fix);
                        default: r_res <= '0;
                    endcase
                end
            end
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

// ----- src/jerk_limited_velocity_shaper_2d_top.sv -----
// Top level of the jerk-limited 2-D velocity shaper: sequencer, state and APB registers.
//
//  channel | direction | handshake        | contents
//  i_in    | in        | valid / ready    | active, setpoint_x, setpoint_y, step_us
//  o_out   | out       | valid / ready    | target_x, target_y, accel_out_x/y, snapped
//  APB     | in        | psel / penable   | speed, accel and jerk limits
//
// An inactive request is answered straight from the idle state. An active request runs on
// the shared unit: each divide by the step time runs one bit per cycle, each square root
// two bits per cycle, each divide by one million takes a reciprocal multiply and a
// correction, and up to three vector limits need a square root and two divides. Reset
// clears the shaper state and loads the default limits. The input is not ready while a
// request is in work or a result waits; a stalled result holds in the output register and
// the last step waits for it to leave.
`include "assert_macros.svh"
module jerk_limited_velocity_shaper_2d_top import jlvs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jlvs_in_if.sink     i_in,
    jlvs_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [28:0] {
        S_IDLE   = 29'd1 << 0,
        S_WAIT   = 29'd1 << 1,
        S_LSETUP = 29'd1 << 2,
        S_LSHIFT = 29'd1 << 3,
        S_LSQB   = 29'd1 << 4,
        S_LSQL   = 29'd1 << 5,
        S_LCMP   = 29'd1 << 6,
        S_LSQRT  = 29'd1 << 7,
        S_LDIVX  = 29'd1 << 8,
        S_LRX    = 29'd1 << 9,
        S_LDIVY  = 29'd1 << 10,
        S_LRY    = 29'd1 << 11,
        S_SPDONE = 29'd1 << 12,
        S_AXDIV  = 29'd1 << 13,
        S_AXRES  = 29'd1 << 14,
        S_AYDIV  = 29'd1 << 15,
        S_AYRES  = 29'd1 << 16,
        S_ACDONE = 29'd1 << 17,
        S_JLDIV  = 29'd1 << 18,
        S_JLRES  = 29'd1 << 19,
        S_JDONE  = 29'd1 << 20,
        S_VXMUL  = 29'd1 << 21,
        S_VXDIV  = 29'd1 << 22,
        S_VXRES  = 29'd1 << 23,
        S_VYDIV  = 29'd1 << 24,
        S_VYRES  = 29'd1 << 25,
        S_DOT1   = 29'd1 << 26,
        S_DOT2   = 29'd1 << 27,
        S_DOT3   = 29'd1 << 28
    } t_state;

    localparam logic signed [47:0] SAT_MAX = 48'sd8388607;
    localparam logic signed [47:0] SAT_MIN = -48'sd8388608;

    function automatic logic [46:0] mag48(input logic signed [47:0] v);
        mag48 = v[47] ? 47'(-v) : 47'(v);
    endfunction

    function automatic logic [24:0] mag25(input logic signed [24:0] v);
        mag25 = v[24] ? -v : v;
    endfunction

    function automatic logic [23:0] mag24(input logic signed [23:0] v);
        mag24 = v[23] ? -v : v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v > SAT_MAX) begin
            sat24 = 24'sh7fffff;
        end else if (v < SAT_MIN) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = v[23:0];
        end
    endfunction

    // Configuration
    logic [17:0] r_speed;
    logic [19:0] r_accel;
    logic [23:0] r_jerk;

    // Sequencer and working registers
    t_state                r_state, n_state;
    t_state                r_next, n_next;
    t_state                r_lret, n_lret;
    logic signed [23:0]    r_vx, n_vx, r_vy, n_vy;
    logic signed [23:0]    r_accx, n_accx, r_accy, n_accy;
    logic signed [23:0]    r_spx, n_spx, r_spy, n_spy;
    logic signed [24:0]    r_ex, n_ex, r_ey, n_ey;
    logic signed [47:0]    r_wx, n_wx, r_wy, n_wy;
    logic [46:0]           r_ua, n_ua, r_ub, n_ub;
    logic                  r_nx, n_nx, r_ny, n_ny;
    logic                  r_shf, n_shf;
    logic [23:0]           r_lim, n_lim;
    logic [DT_W-1:0]       r_dt, n_dt;
    logic [63:0]           r_sum, n_sum;
    logic [31:0]           r_mag, n_mag;
    logic signed [23:0]    r_ntx, n_ntx, r_nty, n_nty;
    logic signed [63:0]    r_dot, n_dot;

    // Output register
    logic                  r_o_valid, n_o_valid;
    logic signed [23:0]    r_o_tx, n_o_tx, r_o_ty, n_o_ty;
    logic signed [23:0]    r_o_ax, n_o_ax, r_o_ay, n_o_ay;
    logic                  r_o_snap, n_o_snap;

    // Shared unit
    t_alu_cmd    u_cmd;
    logic [63:0] u_a;
    logic [31:0] u_b;
    logic [63:0] u_res;
    logic        u_done;

    logic               in_ready;
    logic               out_free;
    logic signed [47:0] res_s;
    logic signed [63:0] res_s64;
    logic signed [24:0] fx, fy;
    logic signed [47:0] vel_sum;
    logic signed [63:0] dot_sum;

    jlvs_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_cmd),
        .i_a     (u_a),
        .i_b     (u_b),
        .o_res   (u_res),
        .o_done  (u_done)
    );

    assign out_free = !r_o_valid || o_out.ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign res_s    = u_res[47:0];
    assign res_s64  = u_res;
    assign fx       = 25'(r_spx) - 25'(r_ntx);
    assign fy       = 25'(r_spy) - 25'(r_nty);

    always_comb begin
        n_state   = r_state;
        n_next    = r_next;
        n_lret    = r_lret;
        n_vx      = r_vx;
        n_vy      = r_vy;
        n_accx    = r_accx;
        n_accy    = r_accy;
        n_spx     = r_spx;
        n_spy     = r_spy;
        n_ex      = r_ex;
        n_ey      = r_ey;
        n_wx      = r_wx;
        n_wy      = r_wy;
        n_ua      = r_ua;
        n_ub      = r_ub;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_shf     = r_shf;
        n_lim     = r_lim;
        n_dt      = r_dt;
        n_sum     = r_sum;
        n_mag     = r_mag;
        n_ntx     = r_ntx;
        n_nty     = r_nty;
        n_dot     = r_dot;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_tx    = r_o_tx;
        n_o_ty    = r_o_ty;
        n_o_ax    = r_o_ax;
        n_o_ay    = r_o_ay;
        n_o_snap  = r_o_snap;
        u_cmd     = '{start: 1'b0, op: OP_MUL};
        u_a       = '0;
        u_b       = '0;
        vel_sum   = '0;
        dot_sum   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && in_ready) begin
                    if (!i_in.active) begin
                        n_vx      = '0;
                        n_vy      = '0;
                        n_accx    = '0;
                        n_accy    = '0;
                        n_o_valid = 1'b1;
                        n_o_tx    = '0;
                        n_o_ty    = '0;
                        n_o_ax    = '0;
                        n_o_ay    = '0;
                        n_o_snap  = 1'b0;
                    end else begin
                        n_wx    = 48'(i_in.setpoint_x);
                        n_wy    = 48'(i_in.setpoint_y);
                        n_lim   = 24'(r_speed);
                        n_dt    = (i_in.step_us == '0) ? DT_W'(1) : i_in.step_us;
                        n_lret  = S_SPDONE;
                        n_state = S_LSETUP;
                    end
                end
            end
            S_WAIT: begin
                if (u_done) begin
                    n_state = r_next;
                end
            end
            // Vector length limit on (r_wx, r_wy) against r_lim, returns to r_lret.
            S_LSETUP: begin
                n_ua    = mag48(r_wx);
                n_ub    = mag48(r_wy);
                n_nx    = r_wx[47];
                n_ny    = r_wy[47];
                n_shf   = 1'b0;
                n_state = S_LSHIFT;
            end
            S_LSHIFT: begin
                if ((|r_ua[46:31]) || (|r_ub[46:31])) begin
                    n_ua  = r_ua >> 1;
                    n_ub  = r_ub >> 1;
                    n_shf = 1'b1;
                end else begin
                    u_cmd   = '{start: 1'b1, op: OP_MUL};
                    u_a     = 64'(r_ua[30:0]);
                    u_b     = 32'(r_ua[30:0]);
                    n_next  = S_LSQB;
                    n_state = S_WAIT;
                end
            end
            S_LSQB: begin
                n_sum   = u_res;
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(r_ub[30:0]);
                u_b     = 32'(r_ub[30:0]);
                n_next  = S_LSQL;
                n_state = S_WAIT;
            end
            S_LSQL: begin
                n_sum   = r_sum + u_res;
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(r_lim);
                u_b     = 32'(r_lim);
                n_next  = S_LCMP;
                n_state = S_WAIT;
            end
            S_LCMP: begin
                if (!r_shf && (r_sum <= u_res)) begin
                    n_state = r_lret;
                end else begin
                    u_cmd   = '{start: 1'b1, op: OP_SQRT};
                    u_a     = r_sum;
                    n_next  = S_LSQRT;
                    n_state = S_WAIT;
                end
            end
            S_LSQRT: begin
                n_mag = u_res[31:0];
                if (u_res[31:0] == '0) begin
                    n_state = r_lret;
                end else begin
                    u_cmd   = '{start: 1'b1, op: OP_MUL};
                    u_a     = 64'(r_ua[30:0]);
                    u_b     = 32'(r_lim);
                    n_next  = S_LDIVX;
                    n_state = S_WAIT;
                end
            end
            S_LDIVX: begin
                u_cmd   = '{start: 1'b1, op: OP_DIV};
                u_a     = u_res;
                u_b     = r_mag;
                n_next  = S_LRX;
                n_state = S_WAIT;
            end
            S_LRX: begin
                n_wx    = r_nx ? -res_s : res_s;
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(r_ub[30:0]);
                u_b     = 32'(r_lim);
                n_next  = S_LDIVY;
                n_state = S_WAIT;
            end
            S_LDIVY: begin
                u_cmd   = '{start: 1'b1, op: OP_DIV};
                u_a     = u_res;
                u_b     = r_mag;
                n_next  = S_LRY;
                n_state = S_WAIT;
            end
            S_LRY: begin
                n_wy    = r_ny ? -res_s : res_s;
                n_state = r_lret;
            end
            S_SPDONE: begin
                n_spx   = r_wx[23:0];
                n_spy   = r_wy[23:0];
                n_ex    = 25'(r_wx) - 25'(r_vx);
                n_ey    = 25'(r_wy) - 25'(r_vy);
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(mag25(n_ex));
                u_b     = US_PER_S;
                n_next  = S_AXDIV;
                n_state = S_WAIT;
            end
            S_AXDIV: begin
                u_cmd   = '{start: 1'b1, op: OP_DIV};
                u_a     = u_res;
                u_b     = 32'(r_dt);
                n_next  = S_AXRES;
                n_state = S_WAIT;
            end
            S_AXRES: begin
                n_wx    = r_ex[24] ? -res_s : res_s;
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(mag25(r_ey));
                u_b     = US_PER_S;
                n_next  = S_AYDIV;
                n_state = S_WAIT;
            end
            S_AYDIV: begin
                u_cmd   = '{start: 1'b1, op: OP_DIV};
                u_a     = u_res;
                u_b     = 32'(r_dt);
                n_next  = S_AYRES;
                n_state = S_WAIT;
            end
            S_AYRES: begin
                n_wy    = r_ey[24] ? -res_s : res_s;
                n_lim   = 24'(r_accel);
                n_lret  = S_ACDONE;
                n_state = S_LSETUP;
            end
            S_ACDONE: begin
                // The limited acceleration becomes the change from the stored one.
                n_wx    = r_wx - 48'(r_accx);
                n_wy    = r_wy - 48'(r_accy);
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(r_jerk);
                u_b     = 32'(r_dt);
                n_next  = S_JLDIV;
                n_state = S_WAIT;
            end
            S_JLDIV: begin
                u_cmd   = '{start: 1'b1, op: OP_DIVM};
                u_a     = u_res;
                n_next  = S_JLRES;
                n_state = S_WAIT;
            end
            S_JLRES: begin
                n_lim   = u_res[23:0];
                n_lret  = S_JDONE;
                n_state = S_LSETUP;
            end
            S_JDONE: begin
                n_accx  = sat24(48'(r_accx) + r_wx);
                n_accy  = sat24(48'(r_accy) + r_wy);
                n_state = S_VXMUL;
            end
            S_VXMUL: begin
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(mag24(r_accx));
                u_b     = 32'(r_dt);
                n_next  = S_VXDIV;
                n_state = S_WAIT;
            end
            S_VXDIV: begin
                u_cmd   = '{start: 1'b1, op: OP_DIVM};
                u_a     = u_res;
                n_next  = S_VXRES;
                n_state = S_WAIT;
            end
            S_VXRES: begin
                vel_sum = 48'(r_vx) + (r_accx[23] ? -res_s : res_s);
                n_ntx   = sat24(vel_sum);
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(mag24(r_accy));
                u_b     = 32'(r_dt);
                n_next  = S_VYDIV;
                n_state = S_WAIT;
            end
            S_VYDIV: begin
                u_cmd   = '{start: 1'b1, op: OP_DIVM};
                u_a     = u_res;
                n_next  = S_VYRES;
                n_state = S_WAIT;
            end
            S_VYRES: begin
                vel_sum = 48'(r_vy) + (r_accy[23] ? -res_s : res_s);
                n_nty   = sat24(vel_sum);
                n_state = S_DOT1;
            end
            S_DOT1: begin
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(mag25(r_ex));
                u_b     = 32'(mag25(fx));
                n_next  = S_DOT2;
                n_state = S_WAIT;
            end
            S_DOT2: begin
                n_dot   = (r_ex[24] ^ fx[24]) ? -res_s64 : res_s64;
                u_cmd   = '{start: 1'b1, op: OP_MUL};
                u_a     = 64'(mag25(r_ey));
                u_b     = 32'(mag25(fy));
                n_next  = S_DOT3;
                n_state = S_WAIT;
            end
            S_DOT3: begin
                dot_sum = r_dot + ((r_ey[24] ^ fy[24]) ? -res_s64 : res_s64);
                // A target that crossed or reached the setpoint snaps onto it.
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (dot_sum <= 64'sd0) begin
                        n_vx     = r_spx;
                        n_vy     = r_spy;
                        n_accx   = '0;
                        n_accy   = '0;
                        n_o_tx   = r_spx;
                        n_o_ty   = r_spy;
                        n_o_ax   = '0;
                        n_o_ay   = '0;
                        n_o_snap = 1'b1;
                    end else begin
                        n_vx     = r_ntx;
                        n_vy     = r_nty;
                        n_o_tx   = r_ntx;
                        n_o_ty   = r_nty;
                        n_o_ax   = r_accx;
                        n_o_ay   = r_accy;
                        n_o_snap = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next    <= S_IDLE;
            r_lret    <= S_IDLE;
            r_vx      <= '0;
            r_vy      <= '0;
            r_accx    <= '0;
            r_accy    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next    <= n_next;
            r_lret    <= n_lret;
            r_vx      <= n_vx;
            r_vy      <= n_vy;
            r_accx    <= n_accx;
            r_accy    <= n_accy;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spx    <= n_spx;
        r_spy    <= n_spy;
        r_ex     <= n_ex;
        r_ey     <= n_ey;
        r_wx     <= n_wx;
        r_wy     <= n_wy;
        r_ua     <= n_ua;
        r_ub     <= n_ub;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_shf    <= n_shf;
        r_lim    <= n_lim;
        r_dt     <= n_dt;
        r_sum    <= n_sum;
        r_mag    <= n_mag;
        r_ntx    <= n_ntx;
        r_nty    <= n_nty;
        r_dot    <= n_dot;
        r_o_tx   <= n_o_tx;
        r_o_ty   <= n_o_ty;
        r_o_ax   <= n_o_ax;
        r_o_ay   <= n_o_ay;
        r_o_snap <= n_o_snap;
    end

    // APB registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RST;
            r_accel <= ACCEL_RST;
            r_jerk  <= JERK_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_SPEED: r_speed <= pwdata[17:0];
                REG_ACCEL: r_accel <= pwdata[19:0];
                REG_JERK:  r_jerk  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED: prdata = 32'(r_speed);
            REG_ACCEL: prdata = 32'(r_accel);
            REG_JERK:  prdata = 32'(r_jerk);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_o_valid;
    assign o_out.target_x    = r_o_tx;
    assign o_out.target_y    = r_o_ty;
    assign o_out.accel_out_x = r_o_ax;
    assign o_out.accel_out_y = r_o_ay;
    assign o_out.snapped     = r_o_snap;

    `ASSERT_SAME(a_ready_idle, i_clk, i_rst_n, i_in.ready, r_state == S_IDLE)
    `ASSERT_SAME(a_snap_zero_accel, i_clk, i_rst_n, r_o_valid && r_o_snap,
                 r_o_ax == '0 && r_o_ay == '0)
    `ASSERT_NEXT(a_inactive_clears, i_clk, i_rst_n,
                 i_in.valid && i_in.ready && !i_in.active,
                 r_o_valid && r_vx == '0 && r_vy == '0 && r_accx == '0 && r_accy == '0)

endmodule
